// ===== hdl/pabc_pkg.sv =====
// Shared constants, types and result layout for the polygon area/box/convexity core.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package pabc_pkg;

  localparam int COORD_BITS    = 16;
  localparam int MAX_VERTICES  = 1024;
  localparam int CNT_BITS      = $clog2(MAX_VERTICES + 1);
  localparam int AREA_BITS     = 2 * COORD_BITS + 11;
  // Running sum needs headroom over the output field before saturation.
  localparam int ACC_BITS      = AREA_BITS + 3;
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS     = 2 * DIFF_BITS;
  localparam int TURN_BITS     = PROD_BITS + 1;
  localparam int CONVEX_MIN_VERTS = 4;
  // Turn lanes in the back end: current turn plus two closing turns.
  localparam int NUM_TURNS     = 3;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

  localparam int IN_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int RES_BITS      = AREA_BITS + 4 * COORD_BITS + 1 + CNT_BITS + 1;
  localparam int OUT_DATA_BITS = ((RES_BITS + 7) / 8) * 8;

  // Saturation bounds of the area field, sign-extended to the accumulator width.
  localparam logic [ACC_BITS-1:0] ACC_AREA_HI =
    {{(ACC_BITS - AREA_BITS + 1){1'b0}}, {(AREA_BITS - 1){1'b1}}};
  localparam logic [ACC_BITS-1:0] ACC_AREA_LO = ~ACC_AREA_HI;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;

  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_SECOND,
    KIND_MID,
    KIND_EXCESS
  } vkind_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
    vkind_t kind;
    cnt_t   cnt;   // vertex count including this one (saturated)
    logic   ovf;   // overflow seen so far in this polygon
  } vtx_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // First member sits in the highest bits, so twice_area lands at bit 0.
  typedef struct packed {
    logic                        overflow;
    cnt_t                        vertex_total;
    logic                        convex;
    coord_t                      box_max_y;
    coord_t                      box_min_y;
    coord_t                      box_max_x;
    coord_t                      box_min_x;
    logic signed [AREA_BITS-1:0] twice_area;
  } result_t;

endpackage

// ===== hdl/pabc_front.sv =====
// Front end: accepts vertices, counts them and tags each with its role in the polygon.
// Depends on pabc_pkg; feeds pabc_fifo.
module pabc_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [pabc_pkg::IN_DATA_BITS-1:0]    in_tdata,
  input  logic                                 in_tlast,
  input  pabc_pkg::fifo_stat_t                 fifo_stat,
  output logic                                 push,
  output pabc_pkg::vtx_item_t                  push_item
);

  pabc_pkg::cnt_t count_r, count_nxt;
  logic           ovf_r, ovf_nxt;
  logic           excess;

  assign in_tready = !fifo_stat.full;
  assign push      = in_tvalid && in_tready;
  assign excess    = (count_r >= pabc_pkg::CNT_BITS'(pabc_pkg::MAX_VERTICES));

  always_comb begin
    push_item.x    = in_tdata[pabc_pkg::COORD_BITS-1:0];
    push_item.y    = in_tdata[2*pabc_pkg::COORD_BITS-1:pabc_pkg::COORD_BITS];
    push_item.last = in_tlast;
    if (excess) begin
      push_item.kind = pabc_pkg::KIND_EXCESS;
    end else if (count_r == '0) begin
      push_item.kind = pabc_pkg::KIND_FIRST;
    end else if (count_r == pabc_pkg::CNT_BITS'(1)) begin
      push_item.kind = pabc_pkg::KIND_SECOND;
    end else begin
      push_item.kind = pabc_pkg::KIND_MID;
    end
    push_item.cnt = excess ? count_r : count_r + 1'b1;
    push_item.ovf = ovf_r | excess;

    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (push) begin
      // Start over after the closing vertex.
      count_nxt = in_tlast ? '0   : push_item.cnt;
      ovf_nxt   = in_tlast ? 1'b0 : push_item.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== hdl/pabc_fifo.sv =====
// Short queue between the front end and the arithmetic back end.
// Depends on pabc_pkg for the item type and depth.
module pabc_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  pabc_pkg::vtx_item_t   push_item,
  input  logic                  pop,
  output pabc_pkg::vtx_item_t   pop_item,
  output pabc_pkg::fifo_stat_t  stat
);

  pabc_pkg::vtx_item_t              mem_r [pabc_pkg::FIFO_DEPTH];
  logic [pabc_pkg::FIFO_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [pabc_pkg::FIFO_AW:0]       level_r, level_nxt;

  assign stat.full  = (level_r == (pabc_pkg::FIFO_AW+1)'(pabc_pkg::FIFO_DEPTH));
  assign stat.empty = (level_r == '0);
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   level_nxt = level_r + 1'b1;
      2'b01:   level_nxt = level_r - 1'b1;
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      level_r <= level_nxt;
    end
  end

endmodule

// ===== hdl/pabc_back.sv =====
// Back end: vertex history, bounding box, product pipeline, area/turn accumulation
// and the output register. Depends on pabc_pkg; drains pabc_fifo.
module pabc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  pabc_pkg::vtx_item_t  item,
  output logic                 item_pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output pabc_pkg::result_t    res_data
);

  typedef logic signed [pabc_pkg::DIFF_BITS-1:0] diff_t;
  typedef logic signed [pabc_pkg::PROD_BITS-1:0] prod_t;
  typedef logic signed [pabc_pkg::TURN_BITS-1:0] turnv_t;
  typedef logic signed [pabc_pkg::ACC_BITS-1:0]  acc_t;

  typedef struct packed {
    diff_t d0;  // a.x - c.x
    diff_t d1;  // b.y - c.y
    diff_t d2;  // a.y - c.y
    diff_t d3;  // b.x - c.x
  } turn_ops_t;

  typedef struct packed {
    prod_t p0;
    prod_t p1;
  } turn_prod_t;

  typedef struct packed {
    logic             last;
    pabc_pkg::cnt_t   cnt;
    logic             ovf;
    pabc_pkg::coord_t min_x;
    pabc_pkg::coord_t max_x;
    pabc_pkg::coord_t min_y;
    pabc_pkg::coord_t max_y;
  } tag_t;

  function automatic diff_t sdiff(pabc_pkg::coord_t a, pabc_pkg::coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic diff_t ssum(pabc_pkg::coord_t a, pabc_pkg::coord_t b);
    return diff_t'(a) + diff_t'(b);
  endfunction

  function automatic turn_ops_t turn_ops(pabc_pkg::coord_t ax, pabc_pkg::coord_t ay,
                                         pabc_pkg::coord_t bx, pabc_pkg::coord_t by,
                                         pabc_pkg::coord_t cx, pabc_pkg::coord_t cy);
    turn_ops_t t;
    t.d0 = sdiff(ax, cx);
    t.d1 = sdiff(by, cy);
    t.d2 = sdiff(ay, cy);
    t.d3 = sdiff(bx, cx);
    return t;
  endfunction

  // Vertex history and box.
  pabc_pkg::coord_t first_x_r, first_y_r, second_x_r, second_y_r;
  pabc_pkg::coord_t prev_x_r, prev_y_r, bp_x_r, bp_y_r;
  pabc_pkg::coord_t first_x_nxt, first_y_nxt, second_x_nxt, second_y_nxt;
  pabc_pkg::coord_t prev_x_nxt, prev_y_nxt, bp_x_nxt, bp_y_nxt;
  pabc_pkg::coord_t min_x_r, max_x_r, min_y_r, max_y_r;
  pabc_pkg::coord_t min_x_nxt, max_x_nxt, min_y_nxt, max_y_nxt;

  logic      adv, take, is_new, has_edge;
  tag_t      tag_nxt;
  diff_t     edge_dx_nxt, edge_sy_nxt, cls_dx_nxt, cls_sy_nxt;
  turn_ops_t ops_nxt [pabc_pkg::NUM_TURNS];
  logic      ten_nxt [pabc_pkg::NUM_TURNS];

  // Stage 1: operands.
  logic      s1_valid_r;
  tag_t      s1_tag_r;
  diff_t     s1_edge_dx_r, s1_edge_sy_r, s1_cls_dx_r, s1_cls_sy_r;
  turn_ops_t s1_ops_r [pabc_pkg::NUM_TURNS];
  logic      s1_ten_r [pabc_pkg::NUM_TURNS];

  // Stage 2: products.
  logic       s2_valid_r;
  tag_t       s2_tag_r;
  prod_t      s2_edge_p_r, s2_cls_p_r;
  turn_prod_t s2_tp_r [pabc_pkg::NUM_TURNS];
  logic       s2_ten_r [pabc_pkg::NUM_TURNS];

  // Stage 3: accumulation and result.
  acc_t              acc_r, acc_nxt, acc_sum, acc_total;
  logic              saw_pos_r, saw_neg_r, saw_pos_nxt, saw_neg_nxt, pos_any, neg_any;
  turnv_t            tv;
  logic              res_valid_r, res_valid_nxt;
  pabc_pkg::result_t res_r, res_nxt;
  logic              emit;

  // Hold the whole pipe only when a finished result cannot leave.
  assign adv       = !(s2_valid_r && s2_tag_r.last && res_valid_r && !res_ready);
  assign take      = item_valid && adv;
  assign item_pop  = take;
  assign emit      = s2_valid_r && s2_tag_r.last && adv;
  assign res_valid = res_valid_r;
  assign res_data  = res_r;

  always_comb begin
    is_new   = (item.kind != pabc_pkg::KIND_EXCESS);
    has_edge = (item.kind == pabc_pkg::KIND_SECOND) || (item.kind == pabc_pkg::KIND_MID);

    first_x_nxt  = (item.kind == pabc_pkg::KIND_FIRST)  ? item.x : first_x_r;
    first_y_nxt  = (item.kind == pabc_pkg::KIND_FIRST)  ? item.y : first_y_r;
    second_x_nxt = (item.kind == pabc_pkg::KIND_SECOND) ? item.x : second_x_r;
    second_y_nxt = (item.kind == pabc_pkg::KIND_SECOND) ? item.y : second_y_r;
    prev_x_nxt   = is_new ? item.x   : prev_x_r;
    prev_y_nxt   = is_new ? item.y   : prev_y_r;
    bp_x_nxt     = is_new ? prev_x_r : bp_x_r;
    bp_y_nxt     = is_new ? prev_y_r : bp_y_r;

    min_x_nxt = min_x_r;
    max_x_nxt = max_x_r;
    min_y_nxt = min_y_r;
    max_y_nxt = max_y_r;
    if (item.kind == pabc_pkg::KIND_FIRST) begin
      min_x_nxt = item.x;
      max_x_nxt = item.x;
      min_y_nxt = item.y;
      max_y_nxt = item.y;
    end else if (has_edge) begin
      if (item.x < min_x_r) min_x_nxt = item.x;
      if (item.x > max_x_r) max_x_nxt = item.x;
      if (item.y < min_y_r) min_y_nxt = item.y;
      if (item.y > max_y_r) max_y_nxt = item.y;
    end

    tag_nxt.last  = item.last;
    tag_nxt.cnt   = item.cnt;
    tag_nxt.ovf   = item.ovf;
    tag_nxt.min_x = min_x_nxt;
    tag_nxt.max_x = max_x_nxt;
    tag_nxt.min_y = min_y_nxt;
    tag_nxt.max_y = max_y_nxt;

    edge_dx_nxt = has_edge ? sdiff(item.x, prev_x_r) : '0;
    edge_sy_nxt = has_edge ? ssum(item.y, prev_y_r)  : '0;
    // Closing edge from the last stored vertex back to the first.
    cls_dx_nxt  = item.last ? sdiff(first_x_nxt, prev_x_nxt) : '0;
    cls_sy_nxt  = item.last ? ssum(first_y_nxt, prev_y_nxt)  : '0;

    ops_nxt[0] = turn_ops(bp_x_r, bp_y_r, prev_x_r, prev_y_r, item.x, item.y);
    ten_nxt[0] = (item.kind == pabc_pkg::KIND_MID);
    ops_nxt[1] = turn_ops(bp_x_nxt, bp_y_nxt, prev_x_nxt, prev_y_nxt,
                          first_x_nxt, first_y_nxt);
    ten_nxt[1] = item.last;
    ops_nxt[2] = turn_ops(prev_x_nxt, prev_y_nxt, first_x_nxt, first_y_nxt,
                          second_x_nxt, second_y_nxt);
    ten_nxt[2] = item.last;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      first_x_r  <= first_x_nxt;
      first_y_r  <= first_y_nxt;
      second_x_r <= second_x_nxt;
      second_y_r <= second_y_nxt;
      prev_x_r   <= prev_x_nxt;
      prev_y_r   <= prev_y_nxt;
      bp_x_r     <= bp_x_nxt;
      bp_y_r     <= bp_y_nxt;
      min_x_r    <= min_x_nxt;
      max_x_r    <= max_x_nxt;
      min_y_r    <= min_y_nxt;
      max_y_r    <= max_y_nxt;
    end
  end

  // Operand and product stages: payload moves with adv.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag_r     <= tag_nxt;
      s1_edge_dx_r <= edge_dx_nxt;
      s1_edge_sy_r <= edge_sy_nxt;
      s1_cls_dx_r  <= cls_dx_nxt;
      s1_cls_sy_r  <= cls_sy_nxt;
      s2_tag_r     <= s1_tag_r;
      s2_edge_p_r  <= s1_edge_dx_r * s1_edge_sy_r;
      s2_cls_p_r   <= s1_cls_dx_r * s1_cls_sy_r;
      for (int i = 0; i < pabc_pkg::NUM_TURNS; i++) begin
        s1_ops_r[i]   <= ops_nxt[i];
        s1_ten_r[i]   <= ten_nxt[i];
        s2_tp_r[i].p0 <= s1_ops_r[i].d0 * s1_ops_r[i].d1;
        s2_tp_r[i].p1 <= s1_ops_r[i].d2 * s1_ops_r[i].d3;
        s2_ten_r[i]   <= s1_ten_r[i];
      end
    end
  end

  always_comb begin
    pos_any = saw_pos_r;
    neg_any = saw_neg_r;
    tv      = '0;
    for (int i = 0; i < pabc_pkg::NUM_TURNS; i++) begin
      tv = turnv_t'(s2_tp_r[i].p0) - turnv_t'(s2_tp_r[i].p1);
      // A zero turn counts as negative.
      if (s2_ten_r[i]) begin
        if (tv > 0) pos_any = 1'b1;
        else        neg_any = 1'b1;
      end
    end

    acc_sum   = acc_r + acc_t'(s2_edge_p_r);
    acc_total = acc_sum + acc_t'(s2_cls_p_r);

    res_nxt.overflow     = s2_tag_r.ovf;
    res_nxt.vertex_total = s2_tag_r.cnt;
    res_nxt.convex       = (s2_tag_r.cnt < pabc_pkg::CNT_BITS'(pabc_pkg::CONVEX_MIN_VERTS)) ?
                           1'b1 : !(pos_any && neg_any);
    res_nxt.box_min_x    = s2_tag_r.min_x;
    res_nxt.box_max_x    = s2_tag_r.max_x;
    res_nxt.box_min_y    = s2_tag_r.min_y;
    res_nxt.box_max_y    = s2_tag_r.max_y;
    if (acc_total > $signed(pabc_pkg::ACC_AREA_HI)) begin
      res_nxt.twice_area = pabc_pkg::ACC_AREA_HI[pabc_pkg::AREA_BITS-1:0];
    end else if (acc_total < $signed(pabc_pkg::ACC_AREA_LO)) begin
      res_nxt.twice_area = pabc_pkg::ACC_AREA_LO[pabc_pkg::AREA_BITS-1:0];
    end else begin
      res_nxt.twice_area = acc_total[pabc_pkg::AREA_BITS-1:0];
    end

    acc_nxt     = acc_r;
    saw_pos_nxt = saw_pos_r;
    saw_neg_nxt = saw_neg_r;
    if (s2_valid_r && adv) begin
      // Clear the running polygon state once the result is out.
      acc_nxt     = s2_tag_r.last ? '0   : acc_sum;
      saw_pos_nxt = s2_tag_r.last ? 1'b0 : pos_any;
      saw_neg_nxt = s2_tag_r.last ? 1'b0 : neg_any;
    end

    if (emit) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      acc_r       <= '0;
      saw_pos_r   <= 1'b0;
      saw_neg_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= item_valid;
        s2_valid_r <= s1_valid_r;
      end
      acc_r       <= acc_nxt;
      saw_pos_r   <= saw_pos_nxt;
      saw_neg_r   <= saw_neg_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

endmodule

// ===== hdl/polygon_area_box_convexity_core.sv =====
// Top level of the polygon area / bounding box / convexity core.
// Depends on pabc_pkg, pabc_front, pabc_fifo and pabc_back.
//
// Usage:
//   Input stream (in_*): one vertex per transaction. in_tdata carries vx and vy,
//   in_tlast marks the closing vertex of a polygon. Any number of vertices may
//   form a polygon; those beyond the vertex limit only raise the overflow flag.
//   Output stream (out_*): one transaction per polygon, produced for the
//   transaction that carried in_tlast: doubled shoelace area (saturated),
//   bounding box, convexity flag, vertex count and overflow flag.
// Throughput: one vertex per clock, sustained, while the output is drained.
//   The per-vertex work is a three-stage pipeline (operands, products,
//   accumulate) fed from a four-entry queue behind the front end.
// Result path: the closing vertex, once popped from the queue, passes the operand
//   stage, the product stage and the output register before out_tvalid rises.
// Reset: rst_n low clears the vertex count, queue, pipeline valids, the area
//   accumulator, the turn flags and the output valid; a polygon in flight is lost.
// Stall: while a result waits on out_tready the pipeline keeps moving vertices
//   of the next polygon; only the next closing vertex freezes the pipe. The
//   queue then fills and in_tready drops until the result is taken.
module polygon_area_box_convexity_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] vx, [31:16] vy
  input  logic [pabc_pkg::IN_DATA_BITS-1:0]   in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [42:0] twice_area, [58:43] box_min_x, [74:59] box_max_x, [90:75] box_min_y,
  // [106:91] box_max_y, [107] convex, [118:108] vertex_total, [119] overflow
  output logic [pabc_pkg::OUT_DATA_BITS-1:0]  out_tdata
);

  pabc_pkg::fifo_stat_t fifo_stat;
  pabc_pkg::vtx_item_t  push_item, pop_item;
  logic                 push, pop;
  pabc_pkg::result_t    res_w;

  // Classify vertices and count them.
  pabc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Decouple the front end from the arithmetic.
  pabc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (fifo_stat)
  );

  // Area, box and turn arithmetic plus the output register.
  pabc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!fifo_stat.empty),
    .item       (pop_item),
    .item_pop   (pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_data   (res_w)
  );

  // Pad the result out to whole bytes.
  assign out_tdata = pabc_pkg::OUT_DATA_BITS'(res_w);

  // Queue level bookkeeping must never report full and empty together.
  a_fifo_level: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("queue reports full and empty at once");

  // A result always covers at least one vertex.
  a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_w.vertex_total != '0))
    else $error("result with zero vertices");

  // Overflow only once the count has saturated.
  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_w.overflow) |->
      (res_w.vertex_total == pabc_pkg::CNT_BITS'(pabc_pkg::MAX_VERTICES)))
    else $error("overflow flagged below the vertex limit");

  // The box seeded from the first vertex is never inverted.
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((res_w.box_min_x <= res_w.box_max_x) &&
                    (res_w.box_min_y <= res_w.box_max_y)))
    else $error("bounding box inverted");

endmodule
